// ===== design/ple_pkg.sv =====
package ple_pkg;

   // Default list depth
   localparam int CAPACITY_DEF = 64;

   // Command codes
   localparam logic [2:0] KIND_APPEND  = 3'd0;
   localparam logic [2:0] KIND_INSERT  = 3'd1;
   localparam logic [2:0] KIND_PREPEND = 3'd2;
   localparam logic [2:0] KIND_RM_HEAD = 3'd3;
   localparam logic [2:0] KIND_RM_TAIL = 3'd4;
   localparam logic [2:0] KIND_RM_AT   = 3'd5;

   // Status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_byte;
      logic [6:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0] removed_byte;
      logic [1:0] status;
      logic [6:0] entries_now;
   } rsp_type;

endpackage

// ===== design/ple_store.sv =====
module ple_store
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [CAPACITY];
   logic [7:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ple_seq.sv =====
module ple_seq
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int SW = (CW > 7) ? CW : 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req_payload,
   output logic          busy,
   output logic          rsp_valid,
   output rsp_type       rsp_payload,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [7:0]    mem_wr_data,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [7:0]    mem_rd_data
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD   = 5'b00010,
      S_WR   = 5'b00100,
      S_PUT  = 5'b01000,
      S_TAKE = 5'b10000
   } state_type;

   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] bound_ff, bound_in;
   logic          ins_ff, ins_in;
   logic [7:0]    data_ff, data_in;
   logic [7:0]    removed_ff, removed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic [6:0]    slot;
   logic [SW-1:0] slot_ext, count_ext, last_ext;
   logic [CW-1:0] last;
   logic [AW-1:0] ins_idx, rm_idx;
   logic [AW-1:0] ptr_step;
   logic          more;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Slot clamping against the current fill
   assign slot      = (req_payload.position == 7'd0) ? 7'd0 : req_payload.position - 7'd1;
   assign slot_ext  = SW'(slot);
   assign count_ext = SW'(count_ff);
   assign last      = count_ff - CW'(1);
   assign last_ext  = SW'(last);

   always_comb begin
      case (req_payload.kind)
         KIND_APPEND: ins_idx = AW'(count_ff);
         KIND_PREPEND: ins_idx = '0;
         default: ins_idx = (slot_ext < count_ext) ? AW'(slot_ext) : AW'(count_ff);
      endcase
      case (req_payload.kind)
         KIND_RM_HEAD: rm_idx = '0;
         KIND_RM_TAIL: rm_idx = AW'(last);
         default: rm_idx = (slot_ext < last_ext) ? AW'(slot_ext) : AW'(last);
      endcase
   end

   // Shared step unit: move the pointer one cell and test against the bound
   assign ptr_step = ins_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
   assign more     = (ptr_step != bound_ff);

   // Memory port steering
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = ptr_step;
      case (state_ff)
         S_IDLE: mem_rd_addr = rm_idx;
         S_WR: mem_wr_en = 1'b1;
         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = bound_ff;
            mem_wr_data = data_ff;
         end
         default: ;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      bound_in     = bound_ff;
      ins_in       = ins_ff;
      data_in      = data_ff;
      removed_in   = removed_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               data_in = req_payload.data_byte;
               case (req_payload.kind) inside
                  KIND_APPEND, KIND_INSERT, KIND_PREPEND: begin
                     if (count_ff >= CAP_COUNT) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{removed_byte: 8'd0, status: ST_FULL,
                                         entries_now: 7'(count_ff)};
                     end else begin
                        ins_in   = 1'b1;
                        ptr_in   = AW'(count_ff);
                        bound_in = ins_idx;
                        state_in = (AW'(count_ff) != ins_idx) ? S_RD : S_PUT;
                     end
                  end
                  KIND_RM_HEAD, KIND_RM_TAIL, KIND_RM_AT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{removed_byte: 8'd0, status: ST_EMPTY,
                                         entries_now: 7'(count_ff)};
                     end else begin
                        ins_in   = 1'b0;
                        ptr_in   = rm_idx;
                        bound_in = AW'(last);
                        state_in = S_TAKE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{removed_byte: 8'd0, status: ST_DONE,
                                      entries_now: 7'(count_ff)};
                  end
               endcase
            end
         end
         S_TAKE: begin
            removed_in = mem_rd_data;
            if (ptr_ff != bound_ff) begin
               state_in = S_RD;
            end else begin
               count_in     = last;
               rsp_valid_in = 1'b1;
               rsp_in       = '{removed_byte: mem_rd_data, status: ST_DONE,
                                entries_now: 7'(last)};
               state_in     = S_IDLE;
            end
         end
         S_RD: state_in = S_WR;
         S_WR: begin
            ptr_in = ptr_step;
            if (more) begin
               state_in = S_RD;
            end else if (ins_ff) begin
               state_in = S_PUT;
            end else begin
               count_in     = last;
               rsp_valid_in = 1'b1;
               rsp_in       = '{removed_byte: removed_ff, status: ST_DONE,
                                entries_now: 7'(last)};
               state_in     = S_IDLE;
            end
         end
         S_PUT: begin
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            rsp_in       = '{removed_byte: 8'd0, status: ST_DONE,
                             entries_now: 7'(count_ff + CW'(1))};
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff     <= ptr_in;
      bound_ff   <= bound_in;
      ins_ff     <= ins_in;
      data_ff    <= data_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A result is only issued while the sequencer is idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE)
      else $error("result strobe while sequencer busy");

   // Fill never exceeds the capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("entry count beyond capacity");

   // A shift step is never issued once the pointer has reached its bound
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> ptr_ff != bound_ff)
      else $error("shift step past bound");

   // The fill only moves together with a result
   a_count_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff) |-> rsp_valid_ff)
      else $error("entry count changed without a result");

endmodule

// ===== design/positional_list_engine_top.sv =====
// Positional list engine: keeps an ordered list of up to CAPACITY bytes in a
// single-port-pair memory and runs one command at a time (append, prepend,
// insert at a 1-based position, remove head, tail or at a position). A command
// transfers on a clock edge with start high and busy low; busy then stays high
// while the sequencer shifts entries one cell per read/write pair. Exactly one
// result per command is shown on rsp_payload for a single cycle with rsp_valid
// high: in the cycle busy falls, or in the cycle after the transfer for refused
// or unused commands, which never raise busy. The receiver cannot stall it and
// must capture it then.
module positional_list_engine_top
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   // Command sequencer with the shared pointer step unit
   ple_seq #(.CAPACITY(CAPACITY)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // List storage
   ple_store #(.CAPACITY(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== bench/ple_list_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and result channels, keeps a shadow copy of the list
// and compares every result with the oldest predicted one.
module ple_list_checker
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_count,
   output int      checked_count
);

   // Shadow list: entries 0..shadow_len-1 are valid, in list order
   logic [7:0] shadow_list [CAPACITY];
   int         shadow_len = 0;

   rsp_type pending_results [$];
   int      mismatch_total = 0;
   int      result_total = 0;

   assign fail_count    = mismatch_total;
   assign pending_count = pending_results.size();
   assign checked_count = result_total;

   // Insert a byte at a 0-based slot, clamped to the end of the list
   function automatic logic [1:0] list_put(int idx, logic [7:0] b);
      if (shadow_len >= CAPACITY) return ST_FULL;
      if (idx > shadow_len) idx = shadow_len;
      for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i - 1];
      shadow_list[idx] = b;
      shadow_len++;
      return ST_DONE;
   endfunction

   // Take the entry at a 0-based slot, clamped to the last entry
   function automatic logic [1:0] list_take(int idx, output logic [7:0] b);
      b = '0;
      if (shadow_len == 0) return ST_EMPTY;
      if (idx >= shadow_len) idx = shadow_len - 1;
      b = shadow_list[idx];
      for (int i = idx; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i + 1];
      shadow_len--;
      return ST_DONE;
   endfunction

   // Apply one command to the shadow list and return its result
   function automatic rsp_type apply_list_command(req_type cmd);
      rsp_type r;
      int      slot;
      slot = (cmd.position == '0) ? 0 : int'(cmd.position) - 1;
      r = '0;
      r.status = ST_DONE;
      case (cmd.kind)
         KIND_APPEND:  r.status = list_put(shadow_len, cmd.data_byte);
         KIND_INSERT:  r.status = list_put(slot, cmd.data_byte);
         KIND_PREPEND: r.status = list_put(0, cmd.data_byte);
         KIND_RM_HEAD: r.status = list_take(0, r.removed_byte);
         KIND_RM_TAIL: r.status = list_take((shadow_len > 0) ? shadow_len - 1 : 0,
                                            r.removed_byte);
         KIND_RM_AT:   r.status = list_take(slot, r.removed_byte);
         default: ;  // spare codes leave the list alone
      endcase
      r.entries_now = shadow_len[6:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
         mismatch_total++;
      end
   endtask

   // New command first, so a result always meets the oldest waiting prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_len = 0;
         pending_results.delete();
      end else begin
         if (start && !busy) pending_results.push_back(apply_list_command(req_payload));
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("%0t ns: unrequested result, expected none, actual 0x%h",
                        $time, rsp_payload);
               mismatch_total++;
            end else begin
               want = pending_results.pop_front();
               check_field("removed_byte", want.removed_byte, rsp_payload.removed_byte);
               check_field("status", 8'(want.status), 8'(rsp_payload.status));
               check_field("entries_now", 8'(want.entries_now), 8'(rsp_payload.entries_now));
               result_total++;
            end
         end
      end
   end

endmodule

// ===== bench/tb_positional_list_engine_top.sv =====
`timescale 1ns / 1ps

module tb_positional_list_engine_top;
   import ple_pkg::*;

   localparam int LIST_DEPTH = CAPACITY_DEF;
   // Codes outside the command set; the block must answer them without changing the list
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;
   localparam int RANDOM_ITEMS = 600;
   localparam int SETTLE_CYCLES = 4 * LIST_DEPTH + 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int checked_count;

   // Stimulus bookkeeping: a rough entry count to steer fill and drain runs
   int entries_guess = 0;
   int useful_sent = 0;
   int ignored_sent = 0;
   int full_refusals = 0;
   int empty_removals = 0;
   int send_idle_pct = 0;

   always #10 clock = ~clock;

   positional_list_engine_top #(.CAPACITY(LIST_DEPTH)) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   ple_list_checker #(.CAPACITY(LIST_DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Drive one command until it transfers, then maybe leave a gap
   task automatic send_command(logic [2:0] kind, logic [7:0] data, logic [6:0] pos);
      req_type cmd;
      cmd.kind = kind;
      cmd.data_byte = data;
      cmd.position = pos;
      start <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (busy);
      case (kind)
         KIND_APPEND, KIND_INSERT, KIND_PREPEND: begin
            useful_sent++;
            if (entries_guess >= LIST_DEPTH) full_refusals++;
            else entries_guess++;
         end
         KIND_RM_HEAD, KIND_RM_TAIL, KIND_RM_AT: begin
            useful_sent++;
            if (entries_guess == 0) empty_removals++;
            else entries_guess--;
         end
         default: ignored_sent++;
      endcase
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Random command; insert_pct biases towards filling or draining
   task automatic send_random(int insert_pct);
      logic [2:0] kind;
      logic [6:0] pos;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 3) kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
      else if ($urandom_range(99) < insert_pct) kind = 3'($urandom_range(2));
      else kind = 3'($urandom_range(5, 3));
      pick = $urandom_range(99);
      if (pick < 5) pos = '0;
      else if (pick < 30) pos = 7'($urandom_range(127));
      else pos = 7'($urandom_range(entries_guess + 1, 1));
      send_command(kind, 8'($urandom_range(255)), pos);
   endtask

   initial begin
      int  phase_end;
      bit  filling;
      filling = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, spare codes, clamped positions, both ends
      send_command(KIND_RM_HEAD, 8'hFF, 7'h7F);
      send_command(KIND_RM_TAIL, 8'h00, 7'h01);
      send_command(KIND_RM_AT,   8'h00, 7'h00);
      send_command(KIND_SPARE6,  8'hFF, 7'h7F);
      send_command(KIND_SPARE7,  8'hA5, 7'h00);
      send_command(KIND_INSERT,  8'h5A, 7'h7F);
      send_command(KIND_INSERT,  8'hFF, 7'h00);
      send_command(KIND_APPEND,  8'h00, 7'h40);
      send_command(KIND_PREPEND, 8'h81, 7'h55);
      send_command(KIND_INSERT,  8'h3C, 7'h03);
      send_command(KIND_INSERT,  8'hC3, 7'h7F);
      send_command(KIND_SPARE7,  8'h11, 7'h02);
      send_command(KIND_RM_AT,   8'h00, 7'h7F);
      send_command(KIND_RM_AT,   8'h00, 7'h00);
      send_command(KIND_RM_AT,   8'h00, 7'h02);
      send_command(KIND_RM_TAIL, 8'h00, 7'h00);
      send_command(KIND_RM_HEAD, 8'h00, 7'h00);
      send_command(KIND_RM_AT,   8'h00, 7'h01);
      send_command(KIND_RM_HEAD, 8'h00, 7'h00);

      // Random: fill to full and drain to empty in turn, over three pacing phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 53 : 0;
         phase_end = useful_sent + RANDOM_ITEMS / 3;
         while (useful_sent < phase_end) begin
            if (entries_guess >= LIST_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
            else if (entries_guess == 0 && $urandom_range(3) == 0) filling = 1'b1;
            else if ($urandom_range(127) == 0) filling = !filling;
            send_random(filling ? 85 : 15);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d list commands and %0d spare codes; %0d results checked.",
               useful_sent, ignored_sent, checked_count);
      $display("Inserts refused on a full list: %0d, removals from an empty list: %0d.",
               full_refusals, empty_removals);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake
   initial begin
      #20_000_000;
      $display("Timeout with %0d results outstanding", pending_count);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
